// ===== rtl/core/mur_pkg.sv =====
// ----------------------------------------------------------------------------
// mur_pkg: shared types and constants of the motor unbinding rate core
// Register indexes, mode codes, item tags carried by the pipeline and the
// elaboration-time root table used by the exponential stages.
// ----------------------------------------------------------------------------
package mur_pkg;

  localparam int NUM_W       = 38;  // quotient divider numerator width
  localparam int DEN_W       = 32;  // quotient divider divisor width
  localparam int POW2_STAGES = 16;  // one stage per fraction bit
  localparam int CDIV_STAGES = 32;  // reciprocal divider quotient bits

  localparam logic [1:0] MODE_FORCE = 2'd0;
  localparam logic [1:0] MODE_CONST = 2'd1;
  localparam logic [1:0] MODE_NONE  = 2'd2;
  localparam logic [1:0] MODE_SPLIT = 2'd3;

  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_BASE   = 3'd1;
  localparam logic [2:0] REG_STALL  = 3'd2;
  localparam logic [2:0] REG_DETACH = 3'd3;
  localparam logic [2:0] REG_A      = 3'd4;
  localparam logic [2:0] REG_B      = 3'd5;
  localparam logic [2:0] REG_LINEAR = 3'd6;

  localparam logic [31:0] RATE_MAX  = 32'hFFFF_FFFF;
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [37:0] EXP_LIMIT = 38'd1507328;  // 23.0 in Q.16
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_EXP,
    KIND_CATCH
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        can;
    logic        last;
    logic [31:0] direct;
  } mur_tag_t;

  typedef struct packed {
    mur_tag_t   tag;
    logic       exp_sat;
    logic [6:0] k;
    logic [6:0] csh;
  } mur_ptag_t;

  function automatic logic [63:0] mur_isqrt(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_w;
    rem   = v;
    res   = '0;
    bit_w = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Q30 factor 2^(2^-j), built by repeated square roots from 2^31.
  function automatic logic [31:0] mur_root(input int j);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 1; i <= POW2_STAGES; i++) begin
      if (i <= j) begin
        r = mur_isqrt(r << 30);
      end
    end
    return r[31:0];
  endfunction

endpackage

// ===== rtl/core/mur_div.sv =====
// ----------------------------------------------------------------------------
// mur_div: pipelined restoring divider
// Produces one quotient bit per stage for the exponent argument.
// ----------------------------------------------------------------------------
module mur_div
  import mur_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  mur_tag_t         in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output mur_tag_t         out_tag
);

  localparam int STAGES = NUM_W;

  logic [STAGES-1:0] vld_r;
  logic [DEN_W-1:0]  rem_r   [STAGES];
  logic [NUM_W-1:0]  num_r   [STAGES];
  logic [NUM_W-1:0]  quo_r   [STAGES];
  logic [DEN_W-1:0]  den_r   [STAGES];
  mur_tag_t          tag_r   [STAGES];
  logic [DEN_W-1:0]  rem_nxt [STAGES];
  logic [NUM_W-1:0]  num_nxt [STAGES];
  logic [NUM_W-1:0]  quo_nxt [STAGES];
  logic [DEN_W-1:0]  src_rem [STAGES];
  logic [NUM_W-1:0]  src_num [STAGES];
  logic [NUM_W-1:0]  src_quo [STAGES];
  logic [DEN_W-1:0]  src_den [STAGES];
  mur_tag_t          src_tag [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    if (s == 0) begin : g_first
      assign src_rem[s] = '0;
      assign src_num[s] = in_num;
      assign src_quo[s] = '0;
      assign src_den[s] = in_den;
      assign src_tag[s] = in_tag;
    end else begin : g_next
      assign src_rem[s] = rem_r[s-1];
      assign src_num[s] = num_r[s-1];
      assign src_quo[s] = quo_r[s-1];
      assign src_den[s] = den_r[s-1];
      assign src_tag[s] = tag_r[s-1];
    end
    assign trial      = {src_rem[s], src_num[s][NUM_W-1]};
    assign ge         = trial >= {1'b0, src_den[s]};
    assign rem_nxt[s] = ge ? DEN_W'(trial - {1'b0, src_den[s]}) : trial[DEN_W-1:0];
    assign num_nxt[s] = {src_num[s][NUM_W-2:0], 1'b0};
    assign quo_nxt[s] = {src_quo[s][NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        num_r[s] <= num_nxt[s];
        quo_r[s] <= quo_nxt[s];
        den_r[s] <= src_den[s];
        tag_r[s] <= src_tag[s];
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];

endmodule

// ===== rtl/core/mur_pow2.sv =====
// ----------------------------------------------------------------------------
// mur_pow2: pipelined fractional power of two
// Builds 2^(arg/2^16) in Q30, one fraction bit and one multiply per stage.
// ----------------------------------------------------------------------------
module mur_pow2
  import mur_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [15:0] in_arg,
  input  mur_ptag_t   in_tag,
  output logic        out_valid,
  output logic [30:0] out_pow,
  output mur_ptag_t   out_tag
);

  logic [POW2_STAGES-1:0] vld_r;
  logic [30:0]            pow_r   [POW2_STAGES];
  logic [15:0]            arg_r   [POW2_STAGES];
  mur_ptag_t              tag_r   [POW2_STAGES];
  logic [30:0]            pow_nxt [POW2_STAGES];
  logic [30:0]            src_pow [POW2_STAGES];
  logic [15:0]            src_arg [POW2_STAGES];
  mur_ptag_t              src_tag [POW2_STAGES];

  for (genvar s = 0; s < POW2_STAGES; s++) begin : g_stage
    localparam logic [30:0] ROOT = 31'(mur_root(s + 1));
    logic [61:0] prod;
    if (s == 0) begin : g_first
      assign src_pow[s] = ONE_Q30;
      assign src_arg[s] = in_arg;
      assign src_tag[s] = in_tag;
    end else begin : g_next
      assign src_pow[s] = pow_r[s-1];
      assign src_arg[s] = arg_r[s-1];
      assign src_tag[s] = tag_r[s-1];
    end
    assign prod       = 62'(src_pow[s]) * 62'(ROOT);
    assign pow_nxt[s] = src_arg[s][POW2_STAGES-1-s] ? prod[60:30] : src_pow[s];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[POW2_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < POW2_STAGES; s++) begin
        pow_r[s] <= pow_nxt[s];
        arg_r[s] <= src_arg[s];
        tag_r[s] <= src_tag[s];
      end
    end
  end

  assign out_valid = vld_r[POW2_STAGES-1];
  assign out_pow   = pow_r[POW2_STAGES-1];
  assign out_tag   = tag_r[POW2_STAGES-1];

endmodule

// ===== rtl/core/motor_unbinding_rate_core.sv =====
// ----------------------------------------------------------------------------
// motor_unbinding_rate_core: force-dependent motor unbinding rate
// An accepted transaction reaches the output through the 38-stage quotient
// divider, the 16-stage power-of-two pipeline and the 32-stage reciprocal
// divider. Throughput is one transaction per cycle while in_stall is low.
// Synchronous reset loads the register defaults and clears all valid bits;
// no clearing pass follows.
// ----------------------------------------------------------------------------
module motor_unbinding_rate_core
  import mur_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_is_bound,
  input  logic [15:0]        in_force_mag,
  input  logic signed [16:0] in_force_x,
  input  logic signed [16:0] in_force_y,
  input  logic signed [16:0] in_force_z,
  input  logic signed [15:0] in_track_dir_x,
  input  logic signed [15:0] in_track_dir_y,
  input  logic signed [15:0] in_track_dir_z,
  input  logic               in_last_motor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_can_unbind,
  output logic [31:0]        out_rate,
  output logic               out_last_result
);

  // Configuration registers
  logic [1:0]  mode_r;
  logic [31:0] base_r;
  logic [15:0] sforce_r;
  logic [15:0] dforce_r;
  logic [31:0] a_r;
  logic [31:0] b_r;
  logic        lin_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_FORCE;
      base_r   <= 32'd65536;
      sforce_r <= 16'd6144;
      dforce_r <= 16'd3072;
      a_r      <= 32'd65536;
      b_r      <= 32'd65536;
      lin_r    <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_MODE:   mode_r   <= pwdata[1:0];
        REG_BASE:   base_r   <= pwdata;
        REG_STALL:  sforce_r <= pwdata[15:0];
        REG_DETACH: dforce_r <= pwdata[15:0];
        REG_A:      a_r      <= pwdata;
        REG_B:      b_r      <= pwdata;
        REG_LINEAR: lin_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MODE:   prdata = {30'b0, mode_r};
      REG_BASE:   prdata = base_r;
      REG_STALL:  prdata = {16'b0, sforce_r};
      REG_DETACH: prdata = {16'b0, dforce_r};
      REG_A:      prdata = a_r;
      REG_B:      prdata = b_r;
      REG_LINEAR: prdata = {31'b0, lin_r};
      default:    prdata = '0;
    endcase
  end

  // The whole pipeline moves together; it halts only when the skid is full.
  logic adv;
  logic skid_valid_r;

  assign adv      = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // Stage 1: input capture
  logic               s1_valid_r;
  logic               s1_bound_r;
  logic [15:0]        s1_f_r;
  logic signed [16:0] s1_fx_r, s1_fy_r, s1_fz_r;
  logic signed [15:0] s1_tx_r, s1_ty_r, s1_tz_r;
  logic               s1_last_r;

  // Stage 2: dot product terms
  logic               s2_valid_r;
  logic               s2_bound_r;
  logic [15:0]        s2_f_r;
  logic signed [32:0] s2_px_r, s2_py_r, s2_pz_r;
  logic               s2_last_r;

  // Stage 3: law selection
  logic               s3_valid_r;
  logic [NUM_W-1:0]   s3_num_r;
  logic [DEN_W-1:0]   s3_den_r;
  mur_tag_t           s3_tag_r;

  logic signed [34:0] dot;
  logic               assist;
  logic [15:0]        fd_eff;
  logic [31:0]        b_eff;
  logic [17:0]        f3;
  logic [47:0]        lin_prod;
  logic [38:0]        lin_sum;
  logic [31:0]        lin_rate;
  logic [NUM_W-1:0]   s3_num_nxt;
  logic [DEN_W-1:0]   s3_den_nxt;
  mur_tag_t           s3_tag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_bound_r <= in_is_bound;
      s1_f_r     <= in_force_mag;
      s1_fx_r    <= in_force_x;
      s1_fy_r    <= in_force_y;
      s1_fz_r    <= in_force_z;
      s1_tx_r    <= in_track_dir_x;
      s1_ty_r    <= in_track_dir_y;
      s1_tz_r    <= in_track_dir_z;
      s1_last_r  <= in_last_motor;
      s2_bound_r <= s1_bound_r;
      s2_f_r     <= s1_f_r;
      s2_px_r    <= s1_fx_r * s1_tx_r;
      s2_py_r    <= s1_fy_r * s1_ty_r;
      s2_pz_r    <= s1_fz_r * s1_tz_r;
      s2_last_r  <= s1_last_r;
      s3_num_r   <= s3_num_nxt;
      s3_den_r   <= s3_den_nxt;
      s3_tag_r   <= s3_tag_nxt;
    end
  end

  always_comb begin
    dot      = 35'(s2_px_r) + 35'(s2_py_r) + 35'(s2_pz_r);
    // A force against the track direction assists the motor off.
    assist   = dot[34];
    fd_eff   = (dforce_r == '0) ? 16'd1 : dforce_r;
    b_eff    = (b_r == '0) ? 32'd1 : b_r;
    f3       = {1'b0, s2_f_r, 1'b0} + {2'b0, s2_f_r};
    lin_prod = 48'(b_r) * 48'(s2_f_r);
    lin_sum  = 39'(a_r) + 39'(lin_prod[47:10]);
    lin_rate = (|lin_sum[38:32]) ? RATE_MAX : lin_sum[31:0];

    s3_tag_nxt.can    = s2_bound_r && (mode_r != MODE_NONE);
    s3_tag_nxt.last   = s2_last_r;
    s3_tag_nxt.kind   = KIND_DIRECT;
    s3_tag_nxt.direct = '0;
    s3_num_nxt        = {s2_f_r, 22'b0};
    s3_den_nxt        = b_eff;
    if (!s3_tag_nxt.can) begin
      s3_tag_nxt.direct = '0;
    end else if (mode_r == MODE_CONST || (mode_r == MODE_SPLIT && s2_f_r == '0)) begin
      s3_tag_nxt.direct = base_r;
    end else if (mode_r == MODE_SPLIT && assist) begin
      s3_tag_nxt.kind = KIND_EXP;
      s3_num_nxt      = NUM_W'({f3, 16'b0});
      s3_den_nxt      = DEN_W'(fd_eff);
    end else if (s2_f_r < sforce_r) begin
      s3_tag_nxt.kind = KIND_EXP;
      s3_num_nxt      = NUM_W'({s2_f_r, 16'b0});
      s3_den_nxt      = DEN_W'(fd_eff);
    end else if (lin_r) begin
      s3_tag_nxt.direct = lin_rate;
    end else begin
      s3_tag_nxt.kind = KIND_CATCH;
    end
  end

  // Exponent argument division
  logic             d_valid;
  logic [NUM_W-1:0] d_quo;
  mur_tag_t         d_tag;

  mur_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s3_valid_r),
    .in_num   (s3_num_r),
    .in_den   (s3_den_r),
    .in_tag   (s3_tag_r),
    .out_valid(d_valid),
    .out_quo  (d_quo),
    .out_tag  (d_tag)
  );

  // Stage Y: scale by log2(e). Arguments past 2^22 give the same outcome as
  // 2^22-1 on every path, so the multiplier sees a clamped value.
  logic        y_valid_r;
  logic [22:0] y_val_r;
  logic        y_sat_r;
  mur_tag_t    y_tag_r;
  logic [21:0] xc;
  logic [38:0] ymul;

  assign xc   = (|d_quo[NUM_W-1:22]) ? '1 : d_quo[21:0];
  assign ymul = 39'(xc) * 39'(LOG2E_Q16);

  // Stage Z: split integer and fraction, form the power-of-two argument
  logic        z_valid_r;
  logic [15:0] z_arg_r;
  mur_ptag_t   z_ptag_r;
  logic [6:0]  yk;
  logic [15:0] yfr;
  logic [15:0] z_arg_nxt;
  mur_ptag_t   z_ptag_nxt;

  always_comb begin
    yk  = y_val_r[22:16];
    yfr = y_val_r[15:0];
    z_ptag_nxt.tag     = y_tag_r;
    z_ptag_nxt.exp_sat = y_sat_r;
    z_ptag_nxt.k       = yk;
    // The catch bond needs 2^-y, taken as 2^(1-f) scaled down by k+1.
    if (y_tag_r.kind == KIND_CATCH && yfr != '0) begin
      z_arg_nxt      = 16'(17'h10000 - {1'b0, yfr});
      z_ptag_nxt.csh = yk + 7'd1;
    end else begin
      z_arg_nxt      = yfr;
      z_ptag_nxt.csh = yk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_valid_r <= 1'b0;
      z_valid_r <= 1'b0;
    end else if (adv) begin
      y_valid_r <= d_valid;
      z_valid_r <= y_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y_val_r  <= ymul[38:16];
      y_sat_r  <= d_quo >= EXP_LIMIT;
      y_tag_r  <= d_tag;
      z_arg_r  <= z_arg_nxt;
      z_ptag_r <= z_ptag_nxt;
    end
  end

  logic        p_valid;
  logic [30:0] p_pow;
  mur_ptag_t   p_ptag;

  mur_pow2 u_pow2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (z_valid_r),
    .in_arg   (z_arg_r),
    .in_tag   (z_ptag_r),
    .out_valid(p_valid),
    .out_pow  (p_pow),
    .out_tag  (p_ptag)
  );

  // Stage F1: scale the exponential by base rate, or form 1 - 2^-y
  logic        f1_valid_r;
  logic [62:0] f1_prod_r;
  logic [30:0] f1_m_r;
  mur_ptag_t   f1_ptag_r;
  logic [62:0] eprod;
  logic [30:0] g_sh;
  logic [30:0] g_val;

  assign eprod = 63'(base_r) * 63'(p_pow);
  assign g_sh  = (p_ptag.csh >= 7'd31) ? '0 : (p_pow >> p_ptag.csh[4:0]);
  assign g_val = (g_sh > ONE_Q30) ? ONE_Q30 : g_sh;

  // Stage F2: exponential shift and saturation, catch bond denominator
  logic        f2_valid_r;
  logic [61:0] f2_den_r;
  logic        f2_csat_r;
  mur_tag_t    f2_tag_r;
  logic [95:0] wide;
  logic [65:0] shv;
  logic [31:0] erate;
  logic [62:0] den;
  mur_tag_t    f2_tag_nxt;

  always_comb begin
    wide = {33'b0, f1_prod_r} << f1_ptag_r.k[5:0];
    shv  = wide[95:30];
    if (base_r == '0) begin
      erate = '0;
    end else if (f1_ptag_r.exp_sat) begin
      erate = RATE_MAX;
    end else begin
      erate = (|shv[65:32]) ? RATE_MAX : shv[31:0];
    end
    den        = 63'(a_r) * 63'(f1_m_r);
    f2_tag_nxt = f1_ptag_r.tag;
    if (f1_ptag_r.tag.kind == KIND_EXP) begin
      f2_tag_nxt.direct = erate;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= p_valid;
      f2_valid_r <= f1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_prod_r <= eprod;
      f1_m_r    <= ONE_Q30 - g_val;
      f1_ptag_r <= p_ptag;
      f2_den_r  <= den[61:0];
      // A quotient of 2^32 or more (zero denominator included) saturates.
      f2_csat_r <= den <= 63'(ONE_Q30);
      f2_tag_r  <= f2_tag_nxt;
    end
  end

  // Reciprocal divider 2^62 / den, one quotient bit per stage
  logic [CDIV_STAGES-1:0] c_vld_r;
  logic [61:0]            c_rem_r   [CDIV_STAGES];
  logic [61:0]            c_den_r   [CDIV_STAGES];
  logic [31:0]            c_quo_r   [CDIV_STAGES];
  logic                   c_csat_r  [CDIV_STAGES];
  mur_tag_t               c_tag_r   [CDIV_STAGES];
  logic [61:0]            c_rem_nxt [CDIV_STAGES];
  logic [31:0]            c_quo_nxt [CDIV_STAGES];
  logic [61:0]            c_src_rem [CDIV_STAGES];
  logic [61:0]            c_src_den [CDIV_STAGES];
  logic [31:0]            c_src_quo [CDIV_STAGES];
  logic                   c_src_sat [CDIV_STAGES];
  mur_tag_t               c_src_tag [CDIV_STAGES];

  for (genvar s = 0; s < CDIV_STAGES; s++) begin : g_cdiv
    logic [62:0] trial;
    logic        ge;
    if (s == 0) begin : g_first
      assign c_src_rem[s] = 62'(ONE_Q30);
      assign c_src_den[s] = f2_den_r;
      assign c_src_quo[s] = '0;
      assign c_src_sat[s] = f2_csat_r;
      assign c_src_tag[s] = f2_tag_r;
    end else begin : g_next
      assign c_src_rem[s] = c_rem_r[s-1];
      assign c_src_den[s] = c_den_r[s-1];
      assign c_src_quo[s] = c_quo_r[s-1];
      assign c_src_sat[s] = c_csat_r[s-1];
      assign c_src_tag[s] = c_tag_r[s-1];
    end
    assign trial        = {c_src_rem[s], 1'b0};
    assign ge           = trial >= {1'b0, c_src_den[s]};
    assign c_rem_nxt[s] = ge ? 62'(trial - {1'b0, c_src_den[s]}) : trial[61:0];
    assign c_quo_nxt[s] = {c_src_quo[s][30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= '0;
    end else if (adv) begin
      c_vld_r <= {c_vld_r[CDIV_STAGES-2:0], f2_valid_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s < CDIV_STAGES; s++) begin
        c_rem_r[s]  <= c_rem_nxt[s];
        c_den_r[s]  <= c_src_den[s];
        c_quo_r[s]  <= c_quo_nxt[s];
        c_csat_r[s] <= c_src_sat[s];
        c_tag_r[s]  <= c_src_tag[s];
      end
    end
  end

  // Final selection and output register with one skid entry
  logic        fin_valid;
  logic [31:0] fin_rate;
  mur_tag_t    fin_tag;
  logic        take;
  logic        out_valid_r;
  logic        out_can_r;
  logic [31:0] out_rate_r;
  logic        out_last_r;
  logic        skid_can_r;
  logic [31:0] skid_rate_r;
  logic        skid_last_r;

  assign fin_valid = c_vld_r[CDIV_STAGES-1];
  assign fin_tag   = c_tag_r[CDIV_STAGES-1];
  assign fin_rate  = (fin_tag.kind == KIND_CATCH)
                   ? (c_csat_r[CDIV_STAGES-1] ? RATE_MAX : c_quo_r[CDIV_STAGES-1])
                   : fin_tag.direct;
  assign take      = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (take) begin
        skid_valid_r <= 1'b0;
      end
    end else if (fin_valid) begin
      if (out_valid_r && !take) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (take) begin
        out_can_r  <= skid_can_r;
        out_rate_r <= skid_rate_r;
        out_last_r <= skid_last_r;
      end
    end else if (fin_valid) begin
      if (out_valid_r && !take) begin
        skid_can_r  <= fin_tag.can;
        skid_rate_r <= fin_rate;
        skid_last_r <= fin_tag.last;
      end else begin
        out_can_r  <= fin_tag.can;
        out_rate_r <= fin_rate;
        out_last_r <= fin_tag.last;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_can_unbind  = out_can_r;
  assign out_rate        = out_rate_r;
  assign out_last_result = out_last_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  a_no_rate_when_bound_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_can_r) |-> (out_rate_r == '0))
    else $error("nonzero rate on a motor that cannot unbind");

endmodule
